@@ hdl/mlr_pkg.sv @@
// mlr_pkg: item kind and slope class codes for the line rasterizer
`timescale 1ns / 1ps
`default_nettype none

package mlr_pkg;

    // item kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // slope classes: bit 0 set means y is the major axis, bit 1 set means falling
    localparam logic [1:0] CLS_SHALLOW_RISE = 2'd0;
    localparam logic [1:0] CLS_STEEP_RISE   = 2'd1;
    localparam logic [1:0] CLS_SHALLOW_FALL = 2'd2;
    localparam logic [1:0] CLS_STEEP_FALL   = 2'd3;

endpackage

`default_nettype wire

@@ hdl/mlr_if.sv @@
// mlr_if: valid/ready channel interfaces for the line rasterizer items
`timescale 1ns / 1ps
`default_nettype none

interface mlr_in_if #(
    parameter int COORD_BITS = 11
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (
        output valid, kind, start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, kind, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

interface mlr_out_if #(
    parameter int COORD_BITS = 11
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last_pixel;
    logic                         no_pixel;

    modport source (
        output valid, pixel_x, pixel_y, last_pixel, no_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, last_pixel, no_pixel,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/midpoint_line_rasterizer.sv @@
// midpoint_line_rasterizer: all-octant midpoint line walker, one pixel per item
`timescale 1ns / 1ps
`default_nettype none

// Midpoint line rasterizer. A load item (kind 0) takes two endpoints and returns
// the first pixel of the line; each advance item (kind 1) returns the next pixel,
// with last_pixel set on the final one. An advance with no line active returns
// a zero pixel with no_pixel set. Every item gives exactly one result item.
// Throughput is one item per clock cycle while the output is ready. An accepted
// item is held in the input register and its result then in the result register.
// The walker state is updated per item by one add on the decision value and
// one compare on the major coordinate, so consecutive advances follow each
// other without gaps while the output is ready. Both registers form a two-stage
// pipeline, so a new item is taken while a result still waits only if the
// input register is empty.
module midpoint_line_rasterizer #(
    parameter int COORD_BITS = 11
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mlr_in_if.sink      i_in,
    mlr_out_if.source   o_out
);

    localparam int W = COORD_BITS + 2;   // walk coordinates
    localparam int D = COORD_BITS + 4;   // decision terms
    localparam logic signed [W-1:0] W_ONE = W'(1);
    localparam logic signed [D-1:0] D_ZERO = '0;

    // input register
    logic                         r_in_vld;
    logic                         r_kind;
    logic signed [COORD_BITS-1:0] r_sx, r_sy, r_ex, r_ey;

    // walker state
    logic signed [W-1:0] r_wx, r_wy, r_mend, r_mir;
    logic signed [D-1:0] r_dec, r_sst, r_sdg;
    logic [1:0]          r_cls;
    logic                r_active;

    // result register
    logic                         r_out_vld;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic                         r_last, r_nopix;

    logic adv, in_ready, step;

    // load path
    logic signed [W-1:0] sx, sy, ex, ey, ax, ay, cx, cy, ay2, cy2;
    logic signed [W-1:0] x0, y0, x1, y1, run, rise, fall, ddx, ddy;
    logic signed [D-1:0] dx, dy;
    logic [1:0]          ld_cls;
    logic                swap_pt, swap_v, falling;

    // next state and result
    logic signed [W-1:0] n_wx, n_wy, n_mend, n_mir, major, px_full;
    logic signed [D-1:0] n_dec, n_sst, n_sdg;
    logic [1:0]          n_cls;
    logic                n_active, do_emit, n_last, n_nopix;
    logic signed [COORD_BITS-1:0] n_px, n_py;

    assign adv      = !r_out_vld || o_out.ready;
    assign in_ready = !r_in_vld || adv;
    assign step     = r_in_vld && adv;

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_in.valid;
        end
        if (in_ready && i_in.valid) begin
            r_kind <= i_in.kind;
            r_sx   <= i_in.start_x;
            r_sy   <= i_in.start_y;
            r_ex   <= i_in.end_x;
            r_ey   <= i_in.end_y;
        end
    end

    // endpoint ordering, slope class and decision set-up
    always_comb begin
        sx = {{2{r_sx[COORD_BITS-1]}}, r_sx};
        sy = {{2{r_sy[COORD_BITS-1]}}, r_sy};
        ex = {{2{r_ex[COORD_BITS-1]}}, r_ex};
        ey = {{2{r_ey[COORD_BITS-1]}}, r_ey};
        swap_pt = sx > ex;
        ax = swap_pt ? ex : sx;
        ay = swap_pt ? ey : sy;
        cx = swap_pt ? sx : ex;
        cy = swap_pt ? sy : ey;
        // vertical line drawn downwards: flip so it is walked upwards in full
        swap_v  = (ax == cx) && (ay > cy);
        ay2     = swap_v ? cy : ay;
        cy2     = swap_v ? ay : cy;
        falling = ay2 > cy2;
        run  = cx - ax;
        rise = cy2 - ay2;
        fall = ay2 - cy2;
        if (!falling) begin
            x0 = ax;
            y0 = ay2;
            x1 = cx;
            y1 = cy2;
            ld_cls = (rise <= run) ? mlr_pkg::CLS_SHALLOW_RISE : mlr_pkg::CLS_STEEP_RISE;
        end else begin
            // falling lines walk mirrored about the right endpoint
            x0 = cx;
            y0 = cy2;
            x1 = (cx <<< 1) - ax;
            y1 = ay2;
            ld_cls = (fall <= run) ? mlr_pkg::CLS_SHALLOW_FALL : mlr_pkg::CLS_STEEP_FALL;
        end
        ddx = x1 - x0;
        ddy = y1 - y0;
        dx  = {{(D-W){ddx[W-1]}}, ddx};
        dy  = {{(D-W){ddy[W-1]}}, ddy};
    end

    always_comb begin
        n_wx     = r_wx;
        n_wy     = r_wy;
        n_mend   = r_mend;
        n_mir    = r_mir;
        n_dec    = r_dec;
        n_sst    = r_sst;
        n_sdg    = r_sdg;
        n_cls    = r_cls;
        n_active = r_active;
        do_emit  = 1'b0;
        n_nopix  = 1'b0;
        if (r_kind == mlr_pkg::KIND_LOAD) begin
            n_cls   = ld_cls;
            n_mir   = cx;
            n_wx    = x0;
            n_wy    = y0;
            do_emit = 1'b1;
            if (ld_cls[0]) begin
                n_dec  = (dx <<< 1) - dy;
                n_sst  = dx <<< 1;
                n_sdg  = (dx - dy) <<< 1;
                n_mend = y1;
            end else begin
                n_dec  = (dy <<< 1) - dx;
                n_sst  = dy <<< 1;
                n_sdg  = (dy - dx) <<< 1;
                n_mend = x1;
            end
        end else if (!r_active) begin
            n_nopix = 1'b1;
        end else begin
            do_emit = 1'b1;
            if (r_dec <= D_ZERO) begin
                n_dec = r_dec + r_sst;
                if (r_cls[0]) begin
                    n_wy = r_wy + W_ONE;
                end else begin
                    n_wx = r_wx + W_ONE;
                end
            end else begin
                n_dec = r_dec + r_sdg;
                n_wx  = r_wx + W_ONE;
                n_wy  = r_wy + W_ONE;
            end
        end
        major   = n_cls[0] ? n_wy : n_wx;
        n_last  = do_emit && (major >= n_mend);
        px_full = n_cls[1] ? ((n_mir <<< 1) - n_wx) : n_wx;
        if (do_emit) begin
            n_active = !n_last;
        end
        n_px = do_emit ? px_full[COORD_BITS-1:0] : '0;
        n_py = do_emit ? n_wy[COORD_BITS-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wx      <= '0;
            r_wy      <= '0;
            r_mend    <= '0;
            r_mir     <= '0;
            r_dec     <= '0;
            r_sst     <= '0;
            r_sdg     <= '0;
            r_cls     <= mlr_pkg::CLS_SHALLOW_RISE;
            r_active  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
            if (step) begin
                r_wx     <= n_wx;
                r_wy     <= n_wy;
                r_mend   <= n_mend;
                r_mir    <= n_mir;
                r_dec    <= n_dec;
                r_sst    <= n_sst;
                r_sdg    <= n_sdg;
                r_cls    <= n_cls;
                r_active <= n_active;
            end
        end
        if (step) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_last  <= n_last;
            r_nopix <= n_nopix;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.pixel_x    = r_px;
    assign o_out.pixel_y    = r_py;
    assign o_out.last_pixel = r_last;
    assign o_out.no_pixel   = r_nopix;

    // a no-pixel item carries a zero pixel and never marks an end of line
    a_nopix_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_nopix) |-> (!r_last && r_px == '0 && r_py == '0))
        else $error("no-pixel result carries pixel data");

    // an advance with no line active gives a no-pixel result next
    a_idle_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_kind == mlr_pkg::KIND_ADVANCE && !r_active) |=>
        (r_out_vld && r_nopix && !r_active))
        else $error("advance without line did not give no-pixel result");

    // the final pixel of a line leaves no line active
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && n_last) |=> !r_active)
        else $error("line still active after final pixel");

    // a load always gives a real pixel
    a_load_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_kind == mlr_pkg::KIND_LOAD) |=> (r_out_vld && !r_nopix))
        else $error("load item gave no pixel");

endmodule

`default_nettype wire
